[rtl/core/moving_average_partial_fill_unit_defines.svh]
// ----------------------------------------------------------------------------
// Moving average unit - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_PARTIAL_FILL_UNIT_DEFINES_SVH
`define MOVING_AVERAGE_PARTIAL_FILL_UNIT_DEFINES_SVH

// Same-cycle implication
`define MAPF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MAPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/mapf_pkg.sv]
// ----------------------------------------------------------------------------
// mapf_pkg
// Widths, control types and sequencer states of the moving average unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mapf_pkg;

  // Window length (number of samples averaged once the ring has filled)
  localparam int WINDOW   = 10;

  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 8;
  localparam int AVG_W    = 24;
  localparam int PTR_W    = $clog2(WINDOW);
  localparam int CNT_W    = $clog2(WINDOW + 1);
  // Exact sum of WINDOW samples never overflows this
  localparam int TOTAL_W  = SAMPLE_W + $clog2(WINDOW);
  // |total| * 2^FRAC_W
  localparam int MAG_W    = TOTAL_W + FRAC_W;
  // floor(2^MAG_W / count), count = 1 needs one extra bit
  localparam int RECIP_W  = MAG_W + 1;

  // Sequencer steps for one item
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_ABS,
    ST_MUL,
    ST_FIX,
    ST_OUT
  } state_t;

  // Ring store controls
  typedef struct packed {
    logic rd;
    logic upd;
  } ring_ctrl_t;

  // Divider controls
  typedef struct packed {
    logic abs_en;
    logic mul_en;
    logic fix_en;
  } div_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/mapf_ring.sv]
// ----------------------------------------------------------------------------
// mapf_ring
// Sample ring in a synchronous memory with write pointer, fill flag and
// running total. Read in one step, modified and written back in the next.
// ----------------------------------------------------------------------------
`default_nettype none

module mapf_ring (
  input  wire                                 clk,
  input  wire                                 rst,
  input  mapf_pkg::ring_ctrl_t                ctrl,
  input  wire logic signed [mapf_pkg::SAMPLE_W-1:0] sample,
  output logic signed [mapf_pkg::TOTAL_W-1:0] total,
  output logic [mapf_pkg::CNT_W-1:0]          count
);
  import mapf_pkg::*;

  logic signed [SAMPLE_W-1:0] ring_mem [WINDOW];
  logic signed [SAMPLE_W-1:0] rd_data;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [PTR_W-1:0]           wr_ptr;
  logic [PTR_W-1:0]           ptr_next;
  logic                       filled;
  logic                       wrap;
  logic signed [TOTAL_W-1:0]  old_ext;
  logic signed [TOTAL_W-1:0]  total_next;

  // Memory: read the slot about to be overwritten, write it back next step
  always_ff @(posedge clk) begin
    if (ctrl.rd) begin
      rd_data  <= ring_mem[wr_ptr];
      sample_q <= sample;
    end
    if (ctrl.upd) begin
      ring_mem[wr_ptr] <= sample_q;
    end
  end

  // Pointer advance and total update; slot reads as zero on the first pass
  always_comb begin
    wrap       = (wr_ptr == PTR_W'(WINDOW - 1));
    ptr_next   = wrap ? '0 : wr_ptr + 1'b1;
    old_ext    = filled ? TOTAL_W'(rd_data) : '0;
    total_next = total - old_ext + TOTAL_W'(sample_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      filled <= 1'b0;
      total  <= '0;
      count  <= '0;
    end else if (ctrl.upd) begin
      wr_ptr <= ptr_next;
      filled <= filled | wrap;
      total  <= total_next;
      count  <= (filled | wrap) ? CNT_W'(WINDOW) : CNT_W'(ptr_next);
    end
  end

endmodule

`default_nettype wire

[rtl/core/mapf_div.sv]
// ----------------------------------------------------------------------------
// mapf_div
// Divides |total| * 256 by the sample count with a reciprocal table, one
// multiply step and one correction step. Gives magnitude and sign.
// ----------------------------------------------------------------------------
`default_nettype none

module mapf_div (
  input  wire                                   clk,
  input  mapf_pkg::div_ctrl_t                   ctrl,
  input  wire logic signed [mapf_pkg::TOTAL_W-1:0] total,
  input  wire logic [mapf_pkg::CNT_W-1:0]       count,
  output logic [mapf_pkg::AVG_W-1:0]            quot,
  output logic                                  neg
);
  import mapf_pkg::*;

  localparam int PROD_W = MAG_W + RECIP_W;
  localparam int FIX_W  = MAG_W + CNT_W;

  logic [RECIP_W-1:0] recip_tab [WINDOW + 1];
  logic [TOTAL_W-1:0] abs_total;
  logic [MAG_W-1:0]   mag;
  logic [CNT_W-1:0]   cnt;
  logic [MAG_W-1:0]   qest;
  logic [PROD_W-1:0]  prod;
  logic [FIX_W-1:0]   back;
  logic [FIX_W-1:0]   rem;
  logic               bump;

  // Reciprocal table, floor(2^MAG_W / c); entry zero never addressed
  assign recip_tab[0] = '0;
  for (genvar i = 1; i <= WINDOW; i++) begin : g_recip
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << MAG_W) / i);
    assign recip_tab[i] = RECIP;
  end

  assign abs_total = total[TOTAL_W-1] ? TOTAL_W'(-total) : TOTAL_W'(total);

  // Estimate is low by at most one
  assign prod = PROD_W'(mag) * PROD_W'(recip_tab[cnt]);
  assign back = FIX_W'(qest) * FIX_W'(cnt);
  assign rem  = FIX_W'(mag) - back;
  assign bump = (rem >= FIX_W'(cnt));

  always_ff @(posedge clk) begin
    if (ctrl.abs_en) begin
      mag <= {abs_total, FRAC_W'(0)};
      neg <= total[TOTAL_W-1];
      cnt <= count;
    end
    if (ctrl.mul_en) begin
      qest <= prod[MAG_W +: MAG_W];
    end
    if (ctrl.fix_en) begin
      quot <= AVG_W'(qest + MAG_W'(bump));
    end
  end

endmodule

`default_nettype wire

[rtl/core/moving_average_partial_fill_unit.sv]
// ----------------------------------------------------------------------------
// moving_average_partial_fill_unit
// Boxcar moving average of signed 16-bit samples with partial-fill start.
// ----------------------------------------------------------------------------
// One item in gives one item out: the mean of the samples seen so far until
// the ring of WINDOW samples first fills, then of the last WINDOW samples,
// as signed Q15.8 truncated toward zero. The unit takes one item at a time
// and no new one until the last is loaded out: a step sequencer runs ring
// read, read-modify-write of ring and running total, magnitude, reciprocal
// multiply, remainder correction and output load. A finished result waits
// in the output register while the next item is taken; the sequencer only
// holds in its last step if the previous result has still not been taken.
// No clearing pass after reset: slots are read as zero until the ring fills.
// ----------------------------------------------------------------------------
`default_nettype none

module moving_average_partial_fill_unit (
  input  wire                                       clk,
  input  wire                                       rst,
  input  wire                                       in_valid,
  output logic                                      in_stall,
  input  wire logic signed [mapf_pkg::SAMPLE_W-1:0] sample,
  output logic                                      out_valid,
  input  wire                                       out_stall,
  output logic signed [mapf_pkg::AVG_W-1:0]         average
);
  import mapf_pkg::*;

  state_t                    state;
  state_t                    state_next;
  ring_ctrl_t                ring_ctrl;
  div_ctrl_t                 div_ctrl;
  logic                      load_out;
  logic signed [TOTAL_W-1:0] total;
  logic [CNT_W-1:0]          count;
  logic [AVG_W-1:0]          quot;
  logic                      neg;

  mapf_ring u_ring (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ring_ctrl),
    .sample (sample),
    .total  (total),
    .count  (count)
  );

  mapf_div u_div (
    .clk   (clk),
    .ctrl  (div_ctrl),
    .total (total),
    .count (count),
    .quot  (quot),
    .neg   (neg)
  );

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer steps
  always_comb begin
    state_next = state;
    ring_ctrl  = '0;
    div_ctrl   = '0;
    load_out   = 1'b0;
    in_stall   = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ring_ctrl.rd = 1'b1;
          state_next   = ST_UPD;
        end
      end
      ST_UPD: begin
        ring_ctrl.upd = 1'b1;
        state_next    = ST_ABS;
      end
      ST_ABS: begin
        div_ctrl.abs_en = 1'b1;
        state_next      = ST_MUL;
      end
      ST_MUL: begin
        div_ctrl.mul_en = 1'b1;
        state_next      = ST_FIX;
      end
      ST_FIX: begin
        div_ctrl.fix_en = 1'b1;
        state_next      = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      average <= neg ? AVG_W'(-quot) : AVG_W'(quot);
    end
  end

endmodule

`default_nettype wire

[rtl/core/mapf_checker.sv]
// ----------------------------------------------------------------------------
// mapf_checker
// Port-level checks of the moving average unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "moving_average_partial_fill_unit_defines.svh"

module mapf_checker (
  input wire                                       clk,
  input wire                                       rst,
  input wire                                       in_valid,
  input wire                                       in_stall,
  input wire                                       out_valid,
  input wire                                       out_stall,
  input wire logic signed [mapf_pkg::AVG_W-1:0]    average
);
  import mapf_pkg::*;

  // Stalled result holds
  `MAPF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(average), "result moved")

  // One item at a time: busy right after taking an item
  `MAPF_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "item taken while busy")

  // An idle unit with nothing offered stays ready
  `MAPF_ASSERT_NEXT(a_idle_stays_ready, !in_valid && !in_stall, !in_stall, "idle unit went busy")

  // A new result only appears while an item is in work
  `MAPF_ASSERT_NOW(a_result_from_item, $rose(out_valid), $past(in_stall), "result without an item")

endmodule

bind moving_average_partial_fill_unit mapf_checker u_mapf_checker (.*);

`default_nettype wire

[test/moving_average_partial_fill_unit_checker.sv]
// ----------------------------------------------------------------------------
// Moving average unit - result checker
// Watches both channels of the unit, works out the expected window mean for
// every accepted sample item and compares each accepted result against the
// oldest expected value. Hands a failure count and the number of results
// still owed to the testbench top.
// ----------------------------------------------------------------------------
`default_nettype none

module moving_average_partial_fill_unit_checker (
  input  wire                                       clk,
  input  wire                                       rst,
  input  wire                                       in_valid,
  input  wire                                       in_stall,
  input  wire logic signed [mapf_pkg::SAMPLE_W-1:0] sample,
  input  wire                                       out_valid,
  input  wire                                       out_stall,
  input  wire logic signed [mapf_pkg::AVG_W-1:0]    average,
  output int                                        fail_count,
  output int                                        outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  import mapf_pkg::*;

  // Own copy of the filter state
  logic signed [SAMPLE_W-1:0] hist_ring [WINDOW];
  logic        [PTR_W-1:0]    hist_ptr;
  logic                       hist_full;
  logic signed [TOTAL_W-1:0]  hist_total;

  // Means still owed by the unit, oldest first
  logic signed [AVG_W-1:0]    pending_means [$];
  logic signed [AVG_W-1:0]    want_mean;

  // Fold one sample into the history and return the new Q15.8 mean
  function automatic logic signed [AVG_W-1:0] fold_sample(
    input logic signed [SAMPLE_W-1:0] s
  );
    int     slot;
    int     divisor;
    longint scaled;
    slot = (hist_ptr < WINDOW) ? int'(hist_ptr) : 0;
    hist_total = hist_total - hist_ring[slot] + s;
    hist_ring[slot] = s;
    slot++;
    if (slot >= WINDOW) begin
      slot      = 0;
      hist_full = 1'b1;
    end
    hist_ptr = PTR_W'(slot);
    divisor = hist_full ? WINDOW : slot;
    if (divisor == 0) divisor = 1;
    scaled = longint'(hist_total) * 256;
    // SystemVerilog division truncates toward zero
    return AVG_W'(scaled / longint'(divisor));
  endfunction

  // Compare on the output channel first, so an item taken at the same edge
  // can never stand in for a result that was not owed
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) hist_ring[i] = '0;
      hist_ptr   = '0;
      hist_full  = 1'b0;
      hist_total = '0;
      pending_means.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_means.size() == 0) begin
          $display("%0t: unexpected average item %0d, none expected", $time, average);
          fail_count++;
        end else begin
          want_mean = pending_means.pop_front();
          if (average !== want_mean) begin
            $display("%0t: average mismatch, expected %0d, actual %0d",
                     $time, want_mean, average);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) pending_means.push_back(fold_sample(sample));
    end
    outstanding = pending_means.size();
  end

endmodule

`default_nettype wire

[test/moving_average_partial_fill_unit_tb.sv]
// ----------------------------------------------------------------------------
// Moving average unit - testbench top
// Drives sample items into the unit with random idle bursts on the input
// side and random stall bursts on the output side, starting with a directed
// run over the partial fill and the field extremes, then mixed random runs.
// The checker beside the unit predicts and compares; this top gives the
// verdict once every owed result has arrived.
// ----------------------------------------------------------------------------
`default_nettype none

module moving_average_partial_fill_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import mapf_pkg::*;

  localparam int RANDOM_ITEMS = 1100;
  localparam int QUIET_ITEMS  = 150;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [AVG_W-1:0]    average;

  int   fail_count;
  int   outstanding;
  logic quiet = 1'b0;
  int   stall_left = 0;

  moving_average_partial_fill_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .average   (average)
  );

  moving_average_partial_fill_unit_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .average     (average),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Random output stall bursts, none in the quiet tail
  always @(negedge clk) begin
    if (rst || quiet) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(1, 14) - 1;
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // Idle gap before the next item
  function automatic int pick_gap();
    if (quiet) return 0;
    if ($urandom_range(0, 4) == 0) return $urandom_range(1, 14);
    return 0;
  endfunction

  // Offer one sample item and hold it until taken
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample   <= value;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold the input off until every owed result has been taken
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Pick a sample for the given random mode
  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int mode);
    case (mode)
      0:       return SAMPLE_W'($urandom);
      1:       return 16'sh7FFF;
      2:       return -16'sh8000;
      3:       return SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
      default: return $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
    endcase
  endfunction

  // Stimulus
  initial begin
    int sent;
    int mode;
    int run_len;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Partial fill at the negative extreme, first item included
    repeat (WINDOW) send_sample(-16'sh8000);
    // Full ring swinging to the positive extreme
    repeat (WINDOW) send_sample(16'sh7FFF);
    // Odd values around zero and bit patterns
    send_sample(16'sh0000);
    send_sample(16'sh0001);
    send_sample(-16'sh0001);
    send_sample(16'sh5555);
    send_sample(-16'sh5556);

    // Mixed random runs
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mode    = $urandom_range(0, 4);
      run_len = (mode == 1 || mode == 2) ? $urandom_range(1, 2 * WINDOW)
                                         : $urandom_range(1, 15);
      for (int j = 0; j < run_len && sent < RANDOM_ITEMS; j++) begin
        send_sample(pick_sample(mode));
        sent++;
        if (sent == RANDOM_ITEMS / 2 || $urandom_range(0, 199) == 0) drain_results();
        quiet = (sent >= RANDOM_ITEMS - QUIET_ITEMS);
      end
    end

    // Wind down and let any late item show up
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

[moving_average_partial_fill_unit.f]
+incdir+rtl/core
rtl/core/mapf_pkg.sv
rtl/core/mapf_ring.sv
rtl/core/mapf_div.sv
rtl/core/moving_average_partial_fill_unit.sv
rtl/core/mapf_checker.sv
test/moving_average_partial_fill_unit_checker.sv
test/moving_average_partial_fill_unit_tb.sv
